### rtl/median_spike_reject_smoother_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the median spike reject smoother
// Shared wrappers for concurrent checks on a clock with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_SPIKE_REJECT_SMOOTHER_MACROS_SVH
`define MEDIAN_SPIKE_REJECT_SMOOTHER_MACROS_SVH

// same-cycle implication
`define MSRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msrs: same-cycle check failed");

// next-cycle implication
`define MSRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msrs: next-cycle check failed");

`endif

### rtl/msrs_pkg.sv
// ----------------------------------------------------------------------------
// Median spike reject smoother package
// Field widths, smoothing coefficients and controller/datapath link types.
// ----------------------------------------------------------------------------
package msrs_pkg;

   localparam int LEVEL_W  = 16;
   localparam int FACTOR_W = 8;
   localparam int ACC_W    = 24;

   localparam logic [FACTOR_W-1:0] SPIKE_FACTOR_RESET = 8'd48;

   // 0.85 and 0.15 as 16-bit fractions, summing to 65536
   localparam logic [15:0] COEF_OLD = 16'd55706;
   localparam logic [15:0] COEF_NEW = 16'd9830;

   localparam int MIN_FOR_MEDIAN = 5;

   typedef struct packed {
      logic capture;
      logic push;
      logic rd_cand;
      logic latch_v;
      logic scan;
      logic next_i;
      logic decide;
      logic mul;
      logic sum;
      logic emit;
   } msrs_cmd_type;

   typedef struct packed {
      logic enough;
      logic j_last;
      logic found;
      logic rsp_free;
   } msrs_status_type;

endpackage

### rtl/msrs_if.sv
// ----------------------------------------------------------------------------
// Median spike reject smoother channels
// Valid/ready channels for the sample item and the result item.
// ----------------------------------------------------------------------------
interface msrs_req_if;
   import msrs_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level_in;

   modport source (output valid, output level_in, input ready);
   modport sink   (input valid, input level_in, output ready);
endinterface

interface msrs_rsp_if;
   import msrs_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] smoothed_level;
   logic [LEVEL_W-1:0] filtered_level;
   logic               spike_flag;

   modport source (output valid, output smoothed_level, output filtered_level,
                   output spike_flag, input ready);
   modport sink   (input valid, input smoothed_level, input filtered_level,
                   input spike_flag, output ready);
endinterface

### rtl/msrs_ctrl.sv
// ----------------------------------------------------------------------------
// Median spike reject smoother controller
// Sequences window push, serial rank search, spike decision and smoothing.
// ----------------------------------------------------------------------------
module msrs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  msrs_pkg::msrs_status_type status,
   output msrs_pkg::msrs_cmd_type    cmd
);
   import msrs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_PICK,
      ST_LOADV,
      ST_WAITV,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK,
      ST_DECIDE,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.push = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = status.enough ? ST_LOADV : ST_MUL;
         end
         ST_LOADV: begin
            cmd.rd_cand = 1'b1;
            state_in    = ST_WAITV;
         end
         ST_WAITV: begin
            cmd.latch_v = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.j_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.found) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.next_i = 1'b1;
               state_in   = ST_LOADV;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/msrs_datapath.sv
// ----------------------------------------------------------------------------
// Median spike reject smoother datapath
// Window memory, rank counters, spike compare, smoothing and output register.
// ----------------------------------------------------------------------------
`include "median_spike_reject_smoother_macros.svh"

module msrs_datapath #(
   parameter int WINDOW = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  msrs_pkg::msrs_cmd_type           cmd,
   output msrs_pkg::msrs_status_type        status,
   input  logic [msrs_pkg::LEVEL_W-1:0]     level_in,
   input  logic [msrs_pkg::FACTOR_W-1:0]    spike_factor,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [msrs_pkg::LEVEL_W-1:0]     smoothed_level,
   output logic [msrs_pkg::LEVEL_W-1:0]     filtered_level,
   output logic                             spike_flag
);
   import msrs_pkg::*;

   localparam int IW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);

   logic [LEVEL_W-1:0] mem [WINDOW];
   logic [LEVEL_W-1:0] rdata_ff;
   logic [LEVEL_W-1:0] sample_ff;
   logic [LEVEL_W-1:0] v_ff;
   logic [LEVEL_W-1:0] filt_ff;
   logic               flag_ff;
   logic [CW-1:0]      fill_ff;
   logic [CW-1:0]      less_ff;
   logic [CW-1:0]      le_ff;
   logic [IW-1:0]      oldest_ff;
   logic [IW-1:0]      i_ff;
   logic [IW-1:0]      j_ff;
   logic               pend_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [39:0]        p_old_ff;
   logic [31:0]        p_new_ff;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] smoothed_ff;
   logic [LEVEL_W-1:0] filtered_ff;
   logic               spike_ff;

   logic               full;
   logic [IW-1:0]      slot;
   logic [IW-1:0]      rd_addr;
   logic [CW-1:0]      rank_k;
   logic [CW-1:0]      fill_m1;
   logic [23:0]        thresh;
   logic [23:0]        level_x16;
   logic [40:0]        acc_sum;
   logic               rsp_free;

   assign full      = (fill_ff == CW'(WINDOW));
   // window stays packed from slot 0 until it first fills
   assign slot      = full ? oldest_ff : fill_ff[IW-1:0];
   assign rd_addr   = cmd.scan ? j_ff : i_ff;
   assign rank_k    = fill_ff >> 1;
   assign fill_m1   = fill_ff - CW'(1);
   assign thresh    = {16'd0, spike_factor} * {8'd0, v_ff};
   assign level_x16 = {4'd0, sample_ff, 4'd0};
   assign acc_sum   = {1'b0, p_old_ff} + {1'b0, p_new_ff, 8'd0};
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign status.enough   = (fill_ff >= CW'(MIN_FOR_MEDIAN));
   assign status.j_last   = (j_ff == fill_m1[IW-1:0]);
   assign status.found    = (less_ff <= rank_k) && (rank_k < le_ff);
   assign status.rsp_free = rsp_free;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[slot] <= sample_ff;
      end
      rdata_ff <= mem[rd_addr];
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= level_in;
      end
      if (cmd.push) begin
         filt_ff <= sample_ff;
         flag_ff <= 1'b0;
         i_ff    <= '0;
      end
      if (cmd.next_i) begin
         i_ff <= i_ff + IW'(1);
      end
      if (cmd.rd_cand) begin
         j_ff    <= '0;
         less_ff <= '0;
         le_ff   <= '0;
      end else if (pend_ff) begin
         if (rdata_ff < v_ff) begin
            less_ff <= less_ff + CW'(1);
         end
         if (rdata_ff <= v_ff) begin
            le_ff <= le_ff + CW'(1);
         end
      end
      if (cmd.scan) begin
         j_ff <= j_ff + IW'(1);
      end
      if (cmd.latch_v) begin
         v_ff <= rdata_ff;
      end
      if (cmd.decide) begin
         if ((v_ff != '0) && (level_x16 > thresh)) begin
            filt_ff <= v_ff;
            flag_ff <= 1'b1;
         end
      end
      if (cmd.mul) begin
         p_old_ff <= 40'(acc_ff) * 40'(COEF_OLD);
         p_new_ff <= 32'(filt_ff) * 32'(COEF_NEW);
      end
      if (cmd.emit) begin
         smoothed_ff <= acc_ff[ACC_W-1:ACC_W-LEVEL_W];
         filtered_ff <= filt_ff;
         spike_ff    <= flag_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         oldest_ff    <= '0;
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan;
         if (cmd.push) begin
            if (!full) begin
               fill_ff <= fill_ff + CW'(1);
            end else begin
               oldest_ff <= (oldest_ff == IW'(WINDOW - 1)) ? '0 : oldest_ff + IW'(1);
            end
         end
         if (cmd.sum) begin
            acc_ff <= acc_sum[39:16];
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign smoothed_level = smoothed_ff;
   assign filtered_level = filtered_ff;
   assign spike_flag     = spike_ff;

   `MSRS_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(WINDOW))
   `MSRS_ASSERT_IMPL(a_oldest_only_full, clock, reset, oldest_ff != '0, full)
   `MSRS_ASSERT_NEXT(a_fill_grow, clock, reset, cmd.push && !full, fill_ff == $past(fill_ff) + CW'(1))
   `MSRS_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready)

endmodule

### rtl/median_spike_reject_smoother.sv
// While the window holds under five samples, the rank search is skipped. Otherwise
// the rank search reads one window entry per cycle from a single memory port,
// candidate by candidate.
// One item in work at a time: a new sample is accepted only when the controller is idle.
// Reset clears fill count, oldest pointer, accumulator and sets spike_factor to 48;
// window memory is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
// Median spike reject smoother
// Sliding-window median spike clamp followed by exponential smoothing.
// ----------------------------------------------------------------------------
module median_spike_reject_smoother #(
   parameter int WINDOW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   msrs_req_if.sink                      req_if,
   msrs_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [msrs_pkg::FACTOR_W-1:0] csr_wr_data
);
   import msrs_pkg::*;

   logic [FACTOR_W-1:0] spike_factor_ff;
   msrs_cmd_type        cmd;
   msrs_status_type     status;

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_factor_ff <= SPIKE_FACTOR_RESET;
      end else if (csr_wr_en) begin
         spike_factor_ff <= csr_wr_data;
      end
   end

   msrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msrs_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .level_in       (req_if.level_in),
      .spike_factor   (spike_factor_ff),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .smoothed_level (rsp_if.smoothed_level),
      .filtered_level (rsp_if.filtered_level),
      .spike_flag     (rsp_if.spike_flag)
   );

endmodule

### bench/median_spike_reject_smoother_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median spike reject smoother checker
// Watches the sample, result and register ports, predicts every result from
// its own copy of the window, threshold and smoothing accumulator, and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module median_spike_reject_smoother_checker #(
   parameter int WINDOW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   msrs_req_if                           req_ch,
   msrs_rsp_if                           rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [msrs_pkg::FACTOR_W-1:0] csr_wr_data,
   output int                            fail_count,
   output int                            outstanding,
   output int                            spike_count
);
   import msrs_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [LEVEL_W-1:0] smoothed;
      logic [LEVEL_W-1:0] filtered;
      logic               spike;
   } smoother_result_type;

   smoother_result_type predicted_results[$];
   smoother_result_type fresh;
   smoother_result_type due;
   logic [LEVEL_W-1:0]  window_levels [WINDOW];
   int                  window_count;
   int                  oldest_index;
   int                  results_seen;
   logic [ACC_W-1:0]    average_acc;
   logic [FACTOR_W-1:0] spike_factor;

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   // upper median of the valid entries: element count/2 in ascending order
   function automatic logic [LEVEL_W-1:0] window_median();
      logic [LEVEL_W-1:0] sorted [WINDOW];
      logic [LEVEL_W-1:0] key;
      int                 j;
      for (int i = 0; i < window_count; i++) begin
         sorted[i] = window_levels[i];
      end
      for (int i = 1; i < window_count; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      return sorted[window_count / 2];
   endfunction

   // push one sample, clamp it if it is a spike, and advance the average
   function automatic smoother_result_type take_level(input logic [LEVEL_W-1:0] level);
      smoother_result_type res;
      logic [LEVEL_W-1:0] mid;
      logic [63:0]        blend;
      res.filtered = level;
      res.spike    = 1'b0;
      if (window_count < WINDOW) begin
         window_levels[(oldest_index + window_count) % WINDOW] = level;
         window_count++;
      end else begin
         window_levels[oldest_index] = level;
         oldest_index = (oldest_index + 1) % WINDOW;
      end
      if (window_count >= MIN_FOR_MEDIAN) begin
         mid = window_median();
         if (mid != '0 && 64'(level) * 64'd16 > 64'(spike_factor) * 64'(mid)) begin
            res.filtered = mid;
            res.spike    = 1'b1;
         end
      end
      blend = 64'(COEF_OLD) * 64'(average_acc) + 64'(COEF_NEW) * (64'(res.filtered) << 8);
      average_acc  = blend[16 +: ACC_W];
      res.smoothed = average_acc[8 +: LEVEL_W];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         spike_factor = SPIKE_FACTOR_RESET;
         window_count = 0;
         oldest_index = 0;
         average_acc  = '0;
         results_seen = 0;
         fail_count   = 0;
         spike_count  = 0;
         predicted_results.delete();
      end else begin
         if (csr_wr_en) begin
            spike_factor = csr_wr_data;
         end
         if (req_ch.valid && req_ch.ready) begin
            fresh = take_level(req_ch.level_in);
            predicted_results.insert(predicted_results.size(), fresh);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no item pending",
                                         results_seen));
            end else begin
               due = predicted_results[0];
               predicted_results.delete(0);
               if (rsp_ch.smoothed_level !== due.smoothed) begin
                  report_mismatch($sformatf("result %0d smoothed_level %0d, expected %0d",
                                            results_seen, rsp_ch.smoothed_level,
                                            due.smoothed));
               end
               if (rsp_ch.filtered_level !== due.filtered) begin
                  report_mismatch($sformatf("result %0d filtered_level %0d, expected %0d",
                                            results_seen, rsp_ch.filtered_level,
                                            due.filtered));
               end
               if (rsp_ch.spike_flag !== due.spike) begin
                  report_mismatch($sformatf("result %0d spike_flag %b, expected %b",
                                            results_seen, rsp_ch.spike_flag, due.spike));
               end
            end
            if (rsp_ch.spike_flag === 1'b1) begin
               spike_count++;
            end
            results_seen++;
         end
      end
      outstanding = predicted_results.size();
   end

endmodule

### bench/median_spike_reject_smoother_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median spike reject smoother testbench
// Feeds directed and random motion levels through the smoother under several
// spike factors and handshake pressure settings; a separate checker predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module median_spike_reject_smoother_test;
   import msrs_pkg::*;

   localparam int WINDOW         = 16;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 70;
   localparam int HOLDOFF_CYCLES = 2000;
   localparam int HOLDOFF_ITEMS  = 14;

   localparam int IDLE_PCTS  [4] = '{0, 54, 0, 21};
   localparam int STALL_PCTS [4] = '{0, 0, 54, 21};

   localparam logic [FACTOR_W-1:0] PHASE_FACTORS [PHASE_COUNT] =
      '{8'd16, 8'd255, 8'd0, 8'd8, 8'd48, 8'd200, 8'd33, 8'd100};

   // short window with zeros, full-scale values, equal-threshold and real spikes
   localparam logic [LEVEL_W-1:0] OPENING_LEVELS [22] = '{
      16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd32768, 16'd1,
      16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
      16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
      16'd3000, 16'd3001, 16'd65535};

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                offer_valid = 1'b0;
   logic [LEVEL_W-1:0]  offer_level = '0;
   logic                take_result = 1'b0;
   logic                csr_wr_en   = 1'b0;
   logic [FACTOR_W-1:0] csr_wr_data = '0;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int holdoff_left  = 0;
   int cycle_count   = 0;
   int samples_sent  = 0;
   int settings_used = 1;
   int trend_level   = 1000;
   int mismatches;
   int waiting_results;
   int spikes_flagged;

   msrs_req_if req_ch ();
   msrs_rsp_if rsp_ch ();

   assign req_ch.valid    = offer_valid;
   assign req_ch.level_in = offer_level;
   assign rsp_ch.ready    = take_result;

   median_spike_reject_smoother #(
      .WINDOW (WINDOW)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   median_spike_reject_smoother_checker #(
      .WINDOW (WINDOW)
   ) smoother_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (mismatches),
      .outstanding (waiting_results),
      .spike_count (spikes_flagged)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, waiting_results);
         $display("median_spike_reject_smoother_test: FAIL");
         $finish;
      end
   end

   // result side: hold off for a counted stretch when asked, else stall at random
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         take_result <= 1'b0;
         holdoff_left--;
      end else begin
         take_result <= ($urandom_range(99) >= stall_pct);
      end
   end

   // level near a drifting trend, with spikes, zeros and full-range noise
   function automatic logic [LEVEL_W-1:0] next_level();
      int roll;
      int span;
      int lvl;
      if ($urandom_range(99) < 5) begin
         trend_level = $urandom_range(1) ? int'($urandom_range(32768))
                                         : int'($urandom_range(300));
      end
      span = trend_level / 8 + 2;
      roll = $urandom_range(99);
      if (roll < 3) begin
         lvl = 0;
      end else if (roll < 70) begin
         lvl = trend_level + int'($urandom_range(span)) - int'($urandom_range(span));
      end else if (roll < 85) begin
         lvl = trend_level * int'($urandom_range(12, 2));
      end else if (roll < 95) begin
         lvl = $urandom_range(32768);
      end else begin
         lvl = $urandom_range(65535);
      end
      if (lvl < 0) lvl = 0;
      if (lvl > 65535) lvl = 65535;
      return lvl[LEVEL_W-1:0];
   endfunction

   task automatic push_level(input logic [LEVEL_W-1:0] level);
      while ($urandom_range(99) < idle_pct) begin
         offer_valid <= 1'b0;
         @(negedge clock);
      end
      offer_valid <= 1'b1;
      offer_level <= level;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
   endtask

   // stop offering and hold until every predicted result is back
   task automatic drain_results();
      offer_valid <= 1'b0;
      while (waiting_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_spike_factor(input logic [FACTOR_W-1:0] factor);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= factor;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [FACTOR_W-1:0] factor;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (OPENING_LEVELS[i]) push_level(OPENING_LEVELS[i]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         factor = (p == PHASE_COUNT - 1) ? FACTOR_W'($urandom_range(255, 16))
                                         : PHASE_FACTORS[p];
         set_spike_factor(factor);
         idle_pct  = IDLE_PCTS[p % 4];
         stall_pct = STALL_PCTS[p % 4];
         repeat (PHASE_ITEMS) push_level(next_level());

         if (p == 3) begin
            // block results for a long stretch while items keep coming
            drain_results();
            idle_pct = 0;
            @(posedge clock);
            holdoff_left = HOLDOFF_CYCLES;
            @(negedge clock);
            repeat (HOLDOFF_ITEMS) push_level(next_level());
         end
      end

      drain_results();
      $display("Sent %0d samples under %0d spike factor settings, %0d results clamped.",
               samples_sent, settings_used, spikes_flagged);
      $display("Covered short windows, wrap-around, zero medians, low factors, %0d-cycle hold-off.",
               HOLDOFF_CYCLES);
      if (mismatches == 0 && waiting_results == 0) begin
         $display("median_spike_reject_smoother_test: PASS");
      end else begin
         $display("median_spike_reject_smoother_test: FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/msrs_pkg.sv
rtl/msrs_if.sv
rtl/msrs_ctrl.sv
rtl/msrs_datapath.sv
rtl/median_spike_reject_smoother.sv
bench/median_spike_reject_smoother_checker.sv
bench/median_spike_reject_smoother_test.sv
